// ===== src/gnd_pkg.sv =====
package gnd_pkg;

  // Field widths of the stream payloads and the configuration port.
  localparam int unsigned AMOUNT_W   = 32;
  localparam int unsigned NOTE_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned OUT_DATA_W = 3 * NOTE_W;

  // One quotient bit is produced per divider step.
  localparam int unsigned DIV_STEPS  = NOTE_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_DENOM_COUNT = cfg_idx_t'(0);
  localparam cfg_idx_t REG_DENOM_A     = cfg_idx_t'(1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the requested amount
    logic sort;       // register the denominations in descending order
    logic skip;       // nothing to divide: the note count is zero
    logic div_start;  // load the divider with the amount owed
    logic div_step;   // one restoring divide step
    logic div_last;   // final step: the remainder becomes the amount owed
    logic emit;       // load the output register
    logic last;       // the emitted result closes the request
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic skip;       // current note value or amount owed is zero
  } status_t;

endpackage

// ===== src/gnd_ctrl.sv =====
module gnd_ctrl #(
  parameter int unsigned MAX_DENOMS = 6,
  parameter int unsigned IdxW       = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1,
  parameter int unsigned CntW       = $clog2(MAX_DENOMS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [CntW-1:0]    n_i,
  input  gnd_pkg::status_t   status_i,
  output gnd_pkg::cmd_t      cmd_o,
  output logic [IdxW-1:0]    idx_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_SETUP,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                           state_q, state_d;
  logic [IdxW-1:0]                  idx_q, idx_d;
  logic [gnd_pkg::DIV_CNT_W-1:0]    div_cnt_q, div_cnt_d;
  logic                             last;
  logic                             div_done;

  // The current result closes the request when it is the last active slot.
  assign last     = (n_i == '0) || ((CntW'(idx_q) + CntW'(1)) == n_i);
  assign div_done = (div_cnt_q == gnd_pkg::DIV_CNT_W'(gnd_pkg::DIV_STEPS - 1));

  // Next state and datapath commands.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    div_cnt_d = div_cnt_q;
    cmd_o     = '0;
    cmd_o.last = last;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SORT;
        end
      end
      ST_SORT: begin
        cmd_o.sort = 1'b1;
        idx_d      = '0;
        if (n_i == '0) begin
          // No denominations: a single result that leaves the amount unpaid.
          cmd_o.skip = 1'b1;
          state_d    = ST_EMIT;
        end else begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (status_i.skip) begin
          cmd_o.skip = 1'b1;
          state_d    = ST_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          div_cnt_d       = '0;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_last = div_done;
        div_cnt_d      = div_cnt_q + 1'b1;
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_SETUP;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign idx_o         = idx_q;

endmodule

// ===== src/gnd_dp.sv =====
module gnd_dp #(
  parameter int unsigned MAX_DENOMS = 6,
  parameter int unsigned IdxW       = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1,
  parameter int unsigned CntW       = $clog2(MAX_DENOMS + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [gnd_pkg::AMOUNT_W-1:0]      s_axis_tdata,  // amount
  input  logic [gnd_pkg::NOTE_W-1:0]        denom_i [MAX_DENOMS],
  input  logic [CntW-1:0]                   n_i,
  input  gnd_pkg::cmd_t                     cmd_i,
  input  logic [IdxW-1:0]                   idx_i,
  output gnd_pkg::status_t                  status_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // note_value, note_count, unpaid
  output logic [gnd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);

  localparam int unsigned W = gnd_pkg::NOTE_W;

  logic [W-1:0]    owed_q;
  logic [W-1:0]    sorted_q [MAX_DENOMS];
  logic [W-1:0]    sorted_d [MAX_DENOMS];
  logic [IdxW-1:0] rank [MAX_DENOMS];
  logic [W-1:0]    quo_q;
  logic [W-1:0]    rem_q;
  logic [W-1:0]    dv;
  logic [W:0]      trial;
  logic [W:0]      diff;
  logic            ge;
  logic [W-1:0]    rem_next;
  logic            out_valid_q;
  logic [gnd_pkg::OUT_DATA_W-1:0] out_data_q;
  logic            out_last_q;

  // Stable descending rank of each active slot: count the slots that sort
  // ahead of it (larger value, or equal value in an earlier register).
  always_comb begin
    for (int i = 0; i < MAX_DENOMS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MAX_DENOMS; j++) begin
        if ((j != i) && (CntW'(j) < n_i) &&
            ((denom_i[j] > denom_i[i]) || ((denom_i[j] == denom_i[i]) && (j < i)))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end
  end

  // Scatter the active slots to their ranked positions.
  always_comb begin
    for (int k = 0; k < MAX_DENOMS; k++) begin
      sorted_d[k] = sorted_q[k];
    end
    for (int i = 0; i < MAX_DENOMS; i++) begin
      if (CntW'(i) < n_i) begin
        sorted_d[rank[i]] = denom_i[i];
      end
    end
  end

  // Restoring divide step: shift in the next dividend bit and try to subtract.
  assign dv       = sorted_q[idx_i];
  assign trial    = {rem_q, quo_q[W-1]};
  assign ge       = (trial >= {1'b0, dv});
  assign diff     = trial - {1'b0, dv};
  assign rem_next = ge ? diff[W-1:0] : trial[W-1:0];

  // Amount owed, sorted note values and divider registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      owed_q <= s_axis_tdata;
    end
    if (cmd_i.sort) begin
      sorted_q <= sorted_d;
    end
    if (cmd_i.skip) begin
      quo_q <= '0;
    end else if (cmd_i.div_start) begin
      quo_q <= owed_q;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[W-2:0], ge};
      rem_q <= rem_next;
      if (cmd_i.div_last) begin
        owed_q <= rem_next;
      end
    end
  end

  // Output register: holds one result until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {owed_q, quo_q, (n_i == '0) ? W'(0) : dv};
      out_last_q <= cmd_i.last;
    end
  end

  assign status_o.out_free = !out_valid_q || m_axis_tready;
  assign status_o.skip     = (dv == '0) || (owed_q == '0);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== src/greedy_note_dispenser.sv =====
// Greedy note dispenser. Each amount request on the slave stream produces one
// result per active denomination, largest note first (equal values keep their
// register order), with the note count, the amount still unpaid and tlast on
// the final one; with no active denominations a single result reports the
// whole amount unpaid. Denominations and their count come from the write-only
// configuration port and must only change while the block is idle. The
// quotients come from one shared radix-2 divider, so each result passes
// through setup, 32 divide steps and the output load, or only setup and the
// output load when the note value or the amount owed is zero. The next
// request is accepted as soon as the last result sits in the output register.
module greedy_note_dispenser #(
  parameter int unsigned MAX_DENOMS = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration writes
  input  logic                                cfg_we_i,
  input  logic [gnd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gnd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Amount requests
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [gnd_pkg::AMOUNT_W-1:0]        s_axis_tdata,  // amount
  // Results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // note_value, note_count, unpaid
  output logic [gnd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tlast
);

  localparam int unsigned IdxW = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
  localparam int unsigned CntW = $clog2(MAX_DENOMS + 1);

  logic [gnd_pkg::COUNT_W-1:0] count_q;
  logic [gnd_pkg::NOTE_W-1:0]  denom_q [MAX_DENOMS];
  logic [CntW-1:0]             n_active;
  gnd_pkg::cmd_t               cmd;
  gnd_pkg::status_t            status;
  logic [IdxW-1:0]             idx;

  // Configuration registers; writes to slots beyond MAX_DENOMS are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int k = 0; k < MAX_DENOMS; k++) begin
        denom_q[k] <= gnd_pkg::NOTE_W'(1);
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gnd_pkg::REG_DENOM_COUNT) begin
        count_q <= cfg_data_i[gnd_pkg::COUNT_W-1:0];
      end
      for (int k = 0; k < MAX_DENOMS; k++) begin
        if (cfg_idx_i == gnd_pkg::cfg_idx_t'(k + 1)) begin
          denom_q[k] <= cfg_data_i[gnd_pkg::NOTE_W-1:0];
        end
      end
    end
  end

  // A count above MAX_DENOMS saturates.
  assign n_active = (count_q > gnd_pkg::COUNT_W'(MAX_DENOMS)) ?
                    CntW'(MAX_DENOMS) : CntW'(count_q);

  gnd_ctrl #(
    .MAX_DENOMS (MAX_DENOMS),
    .IdxW       (IdxW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .n_i           (n_active),
    .status_i      (status),
    .cmd_o         (cmd),
    .idx_o         (idx)
  );

  gnd_dp #(
    .MAX_DENOMS (MAX_DENOMS),
    .IdxW       (IdxW),
    .CntW       (CntW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .denom_i       (denom_q),
    .n_i           (n_active),
    .cmd_i         (cmd),
    .idx_i         (idx),
    .status_o      (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
